@@ sv/evr_pkg.sv @@
`default_nettype none

package evr_pkg;

  localparam int unsigned BASE_W = 8;
  localparam int unsigned POS_W  = 17;
  localparam int unsigned LEN_W  = 16;
  localparam logic [LEN_W-1:0] LEN_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_MATCH = 2'd0,
    OP_INS   = 2'd1,
    OP_DEL   = 2'd2,
    OP_MIS   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_SUB = 2'd0,
    KIND_INS = 2'd1,
    KIND_DEL = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUB,
    S_PRIME_CLOSE,
    S_RUN_CLOSE,
    S_PRIME_END,
    S_RUN_END
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic load_sub;
    logic load_run;
    logic start_close;
    logic start_end;
    logic run_step;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic now_sub;
    logic now_close;
    logic now_end;
    logic has_close;
    logic has_end;
    logic run_at_last;
  } dp_status_t;

endpackage

`default_nettype wire

@@ sv/evr_ram.sv @@
`default_nettype none

module evr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ sv/evr_ctrl.sv @@
`default_nettype none

module evr_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire evr_pkg::dp_status_t status_i,
  output evr_pkg::ctrl_cmd_t       cmd_o
);

  import evr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          priority if (status_i.now_sub) begin
            state_d = S_SUB;
          end else if (status_i.now_close) begin
            state_d = S_PRIME_CLOSE;
          end else if (status_i.now_end) begin
            state_d = S_PRIME_END;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_SUB: begin
        if (status_i.out_free) begin
          cmd_o.load_sub = 1'b1;
          priority if (status_i.has_close) begin
            state_d = S_PRIME_CLOSE;
          end else if (status_i.has_end) begin
            state_d = S_PRIME_END;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_PRIME_CLOSE: begin
        cmd_o.start_close = 1'b1;
        state_d           = S_RUN_CLOSE;
      end
      S_PRIME_END: begin
        cmd_o.start_end = 1'b1;
        state_d         = S_RUN_END;
      end
      S_RUN_CLOSE, S_RUN_END: begin
        if (status_i.out_free) begin
          cmd_o.load_run = 1'b1;
          if (status_i.run_at_last) begin
            state_d = (state_q == S_RUN_CLOSE && status_i.has_end) ? S_PRIME_END : S_IDLE;
          end else begin
            cmd_o.run_step = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/evr_datapath.sv @@
`default_nettype none

module evr_datapath #(
  parameter int unsigned MAX_RUN    = 32,
  parameter int unsigned INDEX_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_wdata_i,
  input  wire logic [1:0]          op_i,
  input  wire logic [7:0]          target_base_i,
  input  wire logic [7:0]          query_base_i,
  input  wire logic                first_op_i,
  input  wire logic                last_op_i,
  input  wire logic signed [16:0]  start_index_i,
  input  wire evr_pkg::ctrl_cmd_t  cmd_i,
  output evr_pkg::dp_status_t      status_o,
  input  wire logic                out_ready_i,
  output logic                     out_valid_o,
  output logic [1:0]               kind_o,
  output logic signed [16:0]       position_o,
  output logic [7:0]               ref_base_o,
  output logic [7:0]               alt_base_o,
  output logic                     run_last_o,
  output logic                     truncated_o
);

  import evr_pkg::*;

  localparam int unsigned IW = INDEX_BITS + 1;
  localparam int unsigned RW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
  localparam int unsigned AW = RW + 1;
  localparam int unsigned RAM_DEPTH = 2 * (2 ** RW);
  localparam logic [LEN_W-1:0] RUN_CAP  = LEN_W'(MAX_RUN);
  localparam logic [RW-1:0]    LAST_MAX = RW'(MAX_RUN - 1);

  // alignment state
  logic              mode_q;
  logic [IW-1:0]     ti_q, ti_d;
  op_e               prev_q, prev_d;
  logic [LEN_W-1:0]  ins_len_q, ins_len_d;
  logic [LEN_W-1:0]  del_len_q, del_len_d;

  // plan of the accepted item
  logic              has_close_q, has_end_q;
  logic [POS_W-1:0]  sub_pos_q;
  logic [BASE_W-1:0] sub_ref_q, sub_alt_q;
  logic              close_del_q, close_trunc_q;
  logic [POS_W-1:0]  close_key_q;
  logic [RW-1:0]     close_last_q;
  logic              end_del_q, end_trunc_q;
  logic [POS_W-1:0]  end_key_q;
  logic [RW-1:0]     end_last_q;

  // current run being drained
  logic              sel_q, sel_d;
  logic [RW-1:0]     idx_q, idx_d;
  logic              cur_trunc_q;
  logic [POS_W-1:0]  cur_key_q;
  logic [RW-1:0]     cur_last_q;

  // output register
  logic              out_valid_q;
  logic [1:0]        kind_q;
  logic [POS_W-1:0]  pos_q;
  logic [BASE_W-1:0] ref_q, alt_q;
  logic              last_q, trunc_q;

  // per-item combinational plan
  op_e               op;
  logic              only_op;
  logic [IW-1:0]     eff_ti;
  op_e               eff_prev;
  logic [LEN_W-1:0]  eff_ins, eff_del, ins_p, del_p;
  logic              close_ins, close_del, end_ins, end_del;
  logic [POS_W-1:0]  ti_pos;
  logic [LEN_W-1:0]  close_len, end_len;
  logic [POS_W-1:0]  close_key, end_key;
  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [BASE_W-1:0] wdata, rdata;

  function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] v);
    return (v == LEN_MAX) ? v : v + LEN_W'(1);
  endfunction

  function automatic logic [RW-1:0] last_idx(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] m1;
    m1 = len - LEN_W'(1);
    return (len > RUN_CAP) ? LAST_MAX : m1[RW-1:0];
  endfunction

  always_comb begin
    op       = op_e'(op_i);
    only_op  = first_op_i & last_op_i;
    eff_ti   = first_op_i ? (mode_q ? IW'(start_index_i) : '1) : ti_q;
    eff_prev = first_op_i ? OP_MATCH : prev_q;
    eff_ins  = first_op_i ? '0 : ins_len_q;
    eff_del  = first_op_i ? '0 : del_len_q;

    // matches, deletions and mismatches step the target
    ti_d  = (!only_op && op != OP_INS) ? eff_ti + IW'(1) : eff_ti;
    ti_pos = POS_W'(signed'(ti_d));

    ins_p = (!only_op && op == OP_INS) ? sat_inc(eff_ins) : eff_ins;
    del_p = (!only_op && op == OP_DEL) ? sat_inc(eff_del) : eff_del;

    we    = !only_op && ((op == OP_INS && eff_ins < RUN_CAP) ||
                         (op == OP_DEL && eff_del < RUN_CAP));
    waddr = (op == OP_DEL) ? {1'b1, eff_del[RW-1:0]} : {1'b0, eff_ins[RW-1:0]};
    wdata = (op == OP_DEL) ? target_base_i : query_base_i;

    close_ins = !only_op && eff_prev == OP_INS && op != OP_INS;
    close_del = !only_op && !close_ins && eff_prev == OP_DEL && op != OP_DEL;
    end_ins   = !only_op && last_op_i && op == OP_INS;
    end_del   = !only_op && last_op_i && op == OP_DEL;

    close_len = close_ins ? ins_p : del_p;
    close_key = ti_pos - POS_W'(close_len);
    end_len   = end_ins ? ins_p : del_p;
    // an insertion run open at the end keys on the index alone
    end_key   = end_ins ? ti_pos : ti_pos - POS_W'(end_len);

    ins_len_d = (close_ins || end_ins) ? '0 : ins_p;
    del_len_d = (close_del || end_del) ? '0 : del_p;
    prev_d    = only_op ? OP_MATCH : op;
  end

  // run read address follows the next index so read data lines up with idx_q
  always_comb begin
    sel_d = sel_q;
    idx_d = idx_q;
    if (cmd_i.start_close) begin
      sel_d = close_del_q;
      idx_d = '0;
    end else if (cmd_i.start_end) begin
      sel_d = end_del_q;
      idx_d = '0;
    end else if (cmd_i.run_step) begin
      idx_d = idx_q + RW'(1);
    end
    raddr = {sel_d, idx_d};
  end

  evr_ram #(
    .WIDTH (BASE_W),
    .DEPTH (RAM_DEPTH)
  ) u_run_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept & we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      ti_q        <= '1;
      prev_q      <= OP_MATCH;
      ins_len_q   <= '0;
      del_len_q   <= '0;
      has_close_q <= 1'b0;
      has_end_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        ti_q        <= ti_d;
        prev_q      <= prev_d;
        ins_len_q   <= ins_len_d;
        del_len_q   <= del_len_d;
        has_close_q <= status_o.now_close;
        has_end_q   <= status_o.now_end;
      end
      if (cmd_i.load_sub || cmd_i.load_run) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sub_pos_q     <= ti_pos;
      sub_ref_q     <= target_base_i;
      sub_alt_q     <= query_base_i;
      close_del_q   <= close_del;
      close_key_q   <= close_key;
      close_last_q  <= last_idx(close_len);
      close_trunc_q <= close_len > RUN_CAP;
      end_del_q     <= end_del;
      end_key_q     <= end_key;
      end_last_q    <= last_idx(end_len);
      end_trunc_q   <= end_len > RUN_CAP;
    end
    sel_q <= sel_d;
    idx_q <= idx_d;
    if (cmd_i.start_close) begin
      cur_key_q   <= close_key_q;
      cur_last_q  <= close_last_q;
      cur_trunc_q <= close_trunc_q;
    end else if (cmd_i.start_end) begin
      cur_key_q   <= end_key_q;
      cur_last_q  <= end_last_q;
      cur_trunc_q <= end_trunc_q;
    end
    if (cmd_i.load_sub) begin
      kind_q  <= KIND_SUB;
      pos_q   <= sub_pos_q;
      ref_q   <= sub_ref_q;
      alt_q   <= sub_alt_q;
      last_q  <= 1'b1;
      trunc_q <= 1'b0;
    end else if (cmd_i.load_run) begin
      kind_q  <= sel_q ? KIND_DEL : KIND_INS;
      pos_q   <= cur_key_q;
      ref_q   <= sel_q ? rdata : '0;
      alt_q   <= sel_q ? '0 : rdata;
      last_q  <= idx_q == cur_last_q;
      trunc_q <= cur_trunc_q;
    end
  end

  always_comb begin
    status_o.out_free    = !out_valid_q || out_ready_i;
    status_o.now_sub     = !only_op && op == OP_MIS;
    status_o.now_close   = (close_ins || close_del) && close_len != '0;
    status_o.now_end     = (end_ins || end_del) && end_len != '0;
    status_o.has_close   = has_close_q;
    status_o.has_end     = has_end_q;
    status_o.run_at_last = idx_q == cur_last_q;
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign position_o  = pos_q;
  assign ref_base_o  = ref_q;
  assign alt_base_o  = alt_q;
  assign run_last_o  = last_q;
  assign truncated_o = trunc_q;

  // never overwrite a record that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_sub || cmd_i.load_run) |-> (!out_valid_q || out_ready_i))
    else $error("output register loaded while occupied");

  // an open insertion run implies the previous op was an insertion and no deletion run is open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ins_len_q != '0) |-> (prev_q == OP_INS && del_len_q == '0))
    else $error("insertion run open without insertion state");

  // drain never steps past the last stored base
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.run_step |-> (idx_q != cur_last_q))
    else $error("run drain stepped past last base");

endmodule

`default_nettype wire

@@ sv/edit_ops_to_variant_records.sv @@
// Edit operations to variant records.
// Input channel (in_valid_i/in_ready_o): one alignment edit op per transfer,
// with the target/query bases it consumes and first/last alignment markers.
// Output channel (out_valid_o/out_ready_i): one variant record per transfer;
// substitutions come out right away, insertion and deletion runs come out
// base by base once they close, all bases of a run carrying the run's key.
// cfg_we_i writes alignment_mode (0 global, 1 semi-global start index).
// Timing: the block works on one op at a time. A mismatch adds a step for
// its substitution. Each closing run adds a step to prime the run buffer
// read, then emits its bases in order (at most MAX_RUN); the run buffer
// read port and the single output register set this sequence. A substitution
// goes from its state into the output register; a run base goes through the
// prime and drain states first. Either waits while the output is occupied.
// Reset: target index -1, previous op match, both runs empty, mode global,
// output empty. No clearing pass; run buffer content is never read before
// it is written.
// Receiver stall: the output register holds its record and the controller
// waits; an op whose records are all in flight may be accepted meanwhile.
`default_nettype none

module edit_ops_to_variant_records #(
  parameter int unsigned MAX_RUN    = 32,
  parameter int unsigned INDEX_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_wdata_i,
  // op input
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         op_i,
  input  wire logic [7:0]         target_base_i,
  input  wire logic [7:0]         query_base_i,
  input  wire logic               first_op_i,
  input  wire logic               last_op_i,
  input  wire logic signed [16:0] start_index_i,
  // record output
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              kind_o,
  output logic signed [16:0]      position_o,
  output logic [7:0]              ref_base_o,
  output logic [7:0]              alt_base_o,
  output logic                    run_last_o,
  output logic                    truncated_o
);

  import evr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer: accept, substitution, run prime/drain
  evr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // index tracking, run buffers, record register
  evr_datapath #(
    .MAX_RUN    (MAX_RUN),
    .INDEX_BITS (INDEX_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .op_i          (op_i),
    .target_base_i (target_base_i),
    .query_base_i  (query_base_i),
    .first_op_i    (first_op_i),
    .last_op_i     (last_op_i),
    .start_index_i (start_index_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .kind_o        (kind_o),
    .position_o    (position_o),
    .ref_base_o    (ref_base_o),
    .alt_base_o    (alt_base_o),
    .run_last_o    (run_last_o),
    .truncated_o   (truncated_o)
  );

endmodule

`default_nettype wire

@@ bench/edit_ops_to_variant_records_tb.sv @@
`timescale 1ns / 100ps

module edit_ops_to_variant_records_tb;
  import evr_pkg::*;

  localparam int unsigned MAX_RUN     = 32;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  // clock edges the bench waits after the last expected record, as the block may still be busy
  localparam int unsigned SETTLE      = 8;

  // clock, reset and block inputs, all known from time zero
  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic               cfg_wdata_i   = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic [1:0]         op_i          = OP_MATCH;
  logic [7:0]         target_base_i = 8'h00;
  logic [7:0]         query_base_i  = 8'h00;
  logic               first_op_i    = 1'b0;
  logic               last_op_i     = 1'b0;
  logic signed [16:0] start_index_i = '0;
  logic               out_ready_i   = 1'b0;

  logic               in_ready_o;
  logic               out_valid_o;
  logic [1:0]         kind_o;
  logic signed [16:0] position_o;
  logic [7:0]         ref_base_o;
  logic [7:0]         alt_base_o;
  logic               run_last_o;
  logic               truncated_o;

  // idling control, changed between phases
  bit          no_gaps   = 1'b0;  // sender keeps valid up back to back
  bit          no_stalls = 1'b0;  // receiver always ready
  int          stall_left = 0;
  int unsigned cycles     = 0;
  int unsigned ops_sent   = 0;

  edit_ops_to_variant_records uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .target_base_i (target_base_i),
    .query_base_i  (query_base_i),
    .first_op_i    (first_op_i),
    .last_op_i     (last_op_i),
    .start_index_i (start_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .position_o    (position_o),
    .ref_base_o    (ref_base_o),
    .alt_base_o    (alt_base_o),
    .run_last_o    (run_last_o),
    .truncated_o   (truncated_o)
  );

  // one variant record as the block should emit it
  typedef struct {
    kind_e       kind;
    logic [16:0] pos;
    logic [7:0]  ref_b;
    logic [7:0]  alt_b;
    logic        last_b;
    logic        trunc;
  } variant_rec_t;

  // Shadow of the block: target index, previous op and the two open runs.
  // note_op() turns each accepted op into the records it should cause;
  // check_record() pops the oldest one and compares it with the transfer.
  class variant_scoreboard;
    bit           mode;
    logic [16:0]  tidx;
    op_e          prev;
    logic [7:0]   ins_buf [MAX_RUN];
    logic [7:0]   del_buf [MAX_RUN];
    logic [15:0]  ins_len;
    logic [15:0]  del_len;
    variant_rec_t pending [$];
    int           errors;

    function new();
      mode    = 1'b0;
      tidx    = '1;
      prev    = OP_MATCH;
      ins_len = '0;
      del_len = '0;
      errors  = 0;
    endfunction

    // append one expected record behind the others
    function void add_rec(variant_rec_t r);
      pending.insert(pending.size(), r);
    endfunction

    // queue every stored base of a closing run under one key
    function void queue_run(kind_e k, logic [16:0] key);
      logic [15:0] len;
      int          n;
      logic [7:0]  b;
      len = (k == KIND_INS) ? ins_len : del_len;
      n   = (len > MAX_RUN) ? int'(MAX_RUN) : int'(len);
      for (int i = 0; i < n; i++) begin
        b = (k == KIND_INS) ? ins_buf[i] : del_buf[i];
        add_rec('{kind: k, pos: key,
                  ref_b: (k == KIND_DEL) ? b : 8'h00,
                  alt_b: (k == KIND_INS) ? b : 8'h00,
                  last_b: (i == n - 1), trunc: (len > MAX_RUN)});
      end
    endfunction

    function void note_op(op_e op, logic [7:0] tb, logic [7:0] qb, logic first,
                          logic last, logic [16:0] start);
      op_e was;
      if (first) begin
        tidx    = mode ? start : '1;
        prev    = OP_MATCH;
        ins_len = '0;
        del_len = '0;
        if (last) return;  // one-op alignment: nothing at all
      end
      was = prev;
      if (op != OP_INS) tidx = tidx + 17'd1;

      case (op)
        OP_MIS: begin
          add_rec('{kind: KIND_SUB, pos: tidx, ref_b: tb, alt_b: qb,
                    last_b: 1'b1, trunc: 1'b0});
        end
        OP_INS: begin
          if (ins_len < MAX_RUN) ins_buf[ins_len] = qb;
          if (ins_len != LEN_MAX) ins_len++;
        end
        OP_DEL: begin
          if (del_len < MAX_RUN) del_buf[del_len] = tb;
          if (del_len != LEN_MAX) del_len++;
        end
        default: ;
      endcase

      // close the run the previous op left open
      if (was == OP_INS && op != OP_INS) begin
        queue_run(KIND_INS, tidx - {1'b0, ins_len});
        ins_len = '0;
      end else if (was == OP_DEL && op != OP_DEL) begin
        queue_run(KIND_DEL, tidx - {1'b0, del_len});
        del_len = '0;
      end

      // runs still open at the end; an insertion keeps the bare index
      if (last) begin
        if (op == OP_INS) begin
          queue_run(KIND_INS, tidx);
          ins_len = '0;
        end else if (op == OP_DEL) begin
          queue_run(KIND_DEL, tidx - {1'b0, del_len});
          del_len = '0;
        end
      end
      prev = op;
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("[%0t] mismatch on %s: got 'h%0h, expected 'h%0h", $realtime, what,
               got, want);
      errors++;
    endtask

    task check_record(logic [1:0] kind, logic [16:0] pos, logic [7:0] rb,
                      logic [7:0] ab, logic rl, logic tr);
      variant_rec_t e;
      if (pending.size() == 0) begin
        report_mismatch("record with nothing expected, position", pos, 0);
        return;
      end
      e = pending.pop_front();
      if (kind !== e.kind)   report_mismatch("kind", kind, e.kind);
      if (pos !== e.pos)     report_mismatch("position", pos, e.pos);
      if (rb !== e.ref_b)    report_mismatch("ref_base", rb, e.ref_b);
      if (ab !== e.alt_b)    report_mismatch("alt_base", ab, e.alt_b);
      if (rl !== e.last_b)   report_mismatch("run_last", rl, e.last_b);
      if (tr !== e.trunc)    report_mismatch("truncated", tr, e.trunc);
    endtask
  endclass

  variant_scoreboard sb;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("edit_ops_to_variant_records_tb failed");
      $finish;
    end
  end

  // Output side: check each record transfer, then pick the next ready.
  // Stalls are mostly short; now and then a long one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_record(kind_o, position_o, ref_base_o, alt_base_o, run_last_o,
                        truncated_o);
      if (no_stalls) begin
        out_ready_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(0, 99) < 25) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 3);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // One op transfer. A gap drops valid first; with no gap valid stays up
  // and only the payload moves on at the edge that took the previous op.
  task automatic send_op(op_e op, logic [7:0] tb, logic [7:0] qb, logic first,
                         logic last, logic [16:0] start);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    target_base_i <= tb;
    query_base_i  <= qb;
    first_op_i    <= first;
    last_op_i     <= last;
    start_index_i <= start;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_op(op, tb, qb, first, last, start);
    ops_sent++;
  endtask

  // hold the sender until every expected record is out, then let the
  // block settle so a write cannot land on an op still in progress
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_mode(bit m);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    sb.mode = m;
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [16:0] pick_start();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 17'h1FFFF;  // -1
    if (r == 1) return 17'h0FFFF;  // top of range, index wraps next step
    return 17'($urandom_range(0, 65535));
  endfunction

  function automatic logic [7:0] rnd_base();
    return 8'($urandom_range(0, 255));
  endfunction

  // One random alignment. Mostly well formed: a first op, runs of
  // insertions/deletions between matches and mismatches, a last op.
  // Now and then plain noise with the markers set at random.
  task automatic send_alignment();
    op_e         ops [$];
    int          want, rl, r;
    bit          noise;
    logic [16:0] start;
    op_e         o;
    noise = ($urandom_range(0, 4) == 0);
    want  = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 10);
    start = pick_start();
    while (ops.size() < want) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        ops = {ops, OP_MATCH};
      end else if (r < 55) begin
        ops = {ops, OP_MIS};
      end else begin
        o  = (r < 78) ? OP_INS : OP_DEL;
        rl = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 36)
                                          : $urandom_range(1, 4);
        repeat (rl) ops = {ops, o};
      end
    end
    foreach (ops[i]) begin
      if (noise)
        send_op(ops[i], rnd_base(), rnd_base(), $urandom_range(0, 7) == 0,
                $urandom_range(0, 7) == 0, pick_start());
      else
        send_op(ops[i], rnd_base(), rnd_base(), i == 0, i == ops.size() - 1,
                start);
    end
  endtask

  task automatic random_phase(int unsigned n_ops);
    int unsigned stop_at;
    stop_at = ops_sent + n_ops;
    while (ops_sent < stop_at) send_alignment();
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed, global mode from reset, no first op yet ---
    send_op(OP_MATCH, 8'h00, 8'h00, 1'b0, 1'b0, '0);
    send_op(OP_MIS,   8'hFF, 8'h00, 1'b0, 1'b0, '0);
    send_op(OP_MIS,   8'h00, 8'hFF, 1'b0, 1'b0, '0);
    send_op(OP_INS,   8'h00, "A",   1'b0, 1'b0, '0);
    send_op(OP_INS,   8'hFF, "C",   1'b0, 1'b0, '0);
    send_op(OP_DEL,   "G",   8'h00, 1'b0, 1'b0, '0);  // insertion closes on deletion
    send_op(OP_DEL,   "T",   8'hFF, 1'b0, 1'b0, '0);
    send_op(OP_INS,   "|",   "N",   1'b0, 1'b0, '0);  // deletion closes on insertion
    send_op(OP_MIS,   "A",   "T",   1'b0, 1'b0, '0);
    send_op(OP_MATCH, "C",   "C",   1'b0, 1'b0, '0);
    send_op(OP_INS,   8'h00, "G",   1'b0, 1'b1, '0);  // insertion open at the end
    send_op(OP_MATCH, "A",   "A",   1'b0, 1'b0, '0);  // past last op, empty run
    send_op(OP_MIS,   "A",   "C",   1'b1, 1'b1, 17'h1FFFF);  // one-op alignment
    send_op(OP_DEL,   "G",   8'h00, 1'b1, 1'b0, 17'h0FFFF);
    send_op(OP_DEL,   "C",   8'h00, 1'b0, 1'b1, '0);  // deletion open at the end
    // run exactly at the buffer size, then one past it
    send_op(OP_MATCH, "A",   "A",   1'b1, 1'b0, '0);
    repeat (MAX_RUN) send_op(OP_INS, 8'h00, rnd_base(), 1'b0, 1'b0, '0);
    send_op(OP_MATCH, "T",   "T",   1'b0, 1'b0, '0);
    repeat (MAX_RUN + 1) send_op(OP_DEL, rnd_base(), 8'h00, 1'b0, 1'b0, '0);
    send_op(OP_MIS,   "G",   "A",   1'b0, 1'b1, '0);

    // --- semi-global: start index extremes and index wrap ---
    drain();
    set_mode(1'b1);
    send_op(OP_MIS,   "A",   "G",   1'b1, 1'b0, 17'h0FFFF);
    send_op(OP_DEL,   "T",   8'h00, 1'b0, 1'b0, '0);
    send_op(OP_MATCH, "C",   "C",   1'b0, 1'b1, '0);
    send_op(OP_MATCH, "C",   "C",   1'b1, 1'b0, 17'h1FFFF);
    send_op(OP_INS,   8'h00, "T",   1'b0, 1'b1, '0);
    send_op(OP_MIS,   "A",   "C",   1'b1, 1'b1, 17'h00000);
    random_phase(45);

    // --- global, back to back on both sides ---
    drain();
    set_mode(1'b0);
    no_gaps   = 1'b1;
    no_stalls = 1'b1;
    random_phase(30);
    no_gaps   = 1'b0;
    no_stalls = 1'b0;
    drain();  // sender holds off until everything is out
    random_phase(30);

    // --- semi-global again ---
    drain();
    set_mode(1'b1);
    random_phase(25);

    // --- global again ---
    drain();
    set_mode(1'b0);
    random_phase(25);

    drain();
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("edit_ops_to_variant_records_tb passed");
    end else begin
      $display("edit_ops_to_variant_records_tb failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/evr_pkg.sv
sv/evr_ram.sv
sv/evr_ctrl.sv
sv/evr_datapath.sv
sv/edit_ops_to_variant_records.sv
bench/edit_ops_to_variant_records_tb.sv
